// ----- hdl/akmt_pkg.sv -----
// akmt_pkg: shared types, codes and reset values for the analog key multi-threshold block
// used by akmt_ctrl, akmt_dp and analog_key_multi_threshold; depends on nothing

package akmt_pkg;

	// default sizes
	localparam int ACTIVE_SLOTS_DEF = 10;
	localparam int MAX_TRIGGERS_DEF = 4;
	localparam int THRESHOLD_REGS   = 4;

	// field widths
	localparam int CMD_W      = 2;
	localparam int POS_W      = 8;
	localparam int VAL_W      = 8;
	localparam int KIND_W     = 2;
	localparam int TRIG_IDX_W = 2;
	localparam int TRIG_CNT_W = 3;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 8;

	// request commands
	localparam logic [CMD_W-1:0] CMD_REGISTER = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE     = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SAMPLE   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;

	// result kinds
	localparam logic [KIND_W-1:0] EV_TRIGGER = 2'd0;
	localparam logic [KIND_W-1:0] EV_FULL    = 2'd1;
	localparam logic [KIND_W-1:0] EV_UNKNOWN = 2'd2;

	// configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_TRIGGER_COUNT = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD_0   = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD_1   = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD_2   = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD_3   = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_HYSTERESIS    = 3'd5;

	// configuration reset values
	localparam logic [TRIG_CNT_W-1:0] TRIG_COUNT_RST = 3'd1;
	localparam logic [VAL_W-1:0] THRESHOLD_RST [THRESHOLD_REGS] = '{8'd128, 8'd160, 8'd192, 8'd224};
	localparam logic [VAL_W-1:0] HYSTERESIS_RST = 8'd2;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [POS_W-1:0] key_position;
		logic [VAL_W-1:0] sample_value;
	} in_item_t;

	typedef struct packed {
		logic [KIND_W-1:0]     event_kind;
		logic [TRIG_IDX_W-1:0] trigger_index;
		logic                  pressed;
		logic                  last;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load_item;
		logic scan_rd;
		logic slot_take;
		logic slot_free;
		logic trig_step;
		logic emit_err;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [CMD_W-1:0] item_cmd;
		logic             hit;
		logic             scan_end;
		logic             out_space;
		logic             trig_last;
		logic             used_zero;
	} dp_stat_t;

endpackage

// ----- hdl/analog_key_multi_threshold.sv -----
// analog_key_multi_threshold: top level, controller plus datapath, result register on the output
// a request scans the slot table one slot per cycle until it hits or passes the last slot
// a sample that hits then steps one trigger per cycle while the result register has space
// requests are taken one at a time, the next only once the controller is back in idle; held results stall
// reset: arst_n clears slot occupancy, trigger states and control; configuration returns to defaults
// depends on akmt_pkg, akmt_ctrl, akmt_dp

module analog_key_multi_threshold #(
	parameter int ACTIVE_SLOTS = akmt_pkg::ACTIVE_SLOTS_DEF,
	parameter int MAX_TRIGGERS = akmt_pkg::MAX_TRIGGERS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  akmt_pkg::in_item_t               in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output akmt_pkg::out_item_t              out_data,
	input  logic                             cfg_we,
	input  logic [akmt_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [akmt_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import akmt_pkg::*;

	ctrl_cmd_t ctrl_cmd;
	dp_stat_t  dp_stat;

	// sequencing
	akmt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (dp_stat),
		.cmd      (ctrl_cmd)
	);

	// storage and compare
	akmt_dp #(
		.ACTIVE_SLOTS (ACTIVE_SLOTS),
		.MAX_TRIGGERS (MAX_TRIGGERS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cmd       (ctrl_cmd),
		.stat      (dp_stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// a taken request keeps the block busy for at least the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while previous one in flight");

	// more results of the same request follow, so no new request may be taken
	a_not_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last |-> !in_ready)
		else $error("idle with results still pending");

	// error results stand alone with cleared trigger fields
	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.event_kind != EV_TRIGGER |->
			out_data.last && out_data.trigger_index == '0 && !out_data.pressed)
		else $error("malformed error result");

	// table updates, trigger steps, error emission and capture never overlap
	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctrl_cmd.load_item, ctrl_cmd.slot_take, ctrl_cmd.slot_free,
			ctrl_cmd.trig_step, ctrl_cmd.emit_err}))
		else $error("conflicting datapath commands");

endmodule

// ----- hdl/akmt_ctrl.sv -----
// akmt_ctrl: sequencing state machine for the analog key multi-threshold block
// depends on akmt_pkg; drives akmt_dp through ctrl_cmd_t and reads dp_stat_t

module akmt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  akmt_pkg::dp_stat_t   stat,
	output akmt_pkg::ctrl_cmd_t  cmd
);
	import akmt_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_TRIG = 2'd2;
	localparam logic [1:0] ST_ERR  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// next state and commands
	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.item_cmd == CMD_UNUSED) begin
					state_d = ST_IDLE;
				end else if (stat.hit) begin
					unique case (stat.item_cmd)
						CMD_REGISTER: begin
							cmd.slot_take = 1'b1;
							state_d       = ST_IDLE;
						end
						CMD_FREE: begin
							cmd.slot_free = 1'b1;
							state_d       = ST_IDLE;
						end
						CMD_SAMPLE: begin
							state_d = stat.used_zero ? ST_IDLE : ST_TRIG;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end else if (stat.scan_end) begin
					if (stat.item_cmd == CMD_SAMPLE) begin
						state_d = ST_IDLE;
					end else begin
						state_d = ST_ERR;
					end
				end else begin
					cmd.scan_rd = 1'b1;
				end
			end
			ST_TRIG: begin
				if (stat.out_space) begin
					cmd.trig_step = 1'b1;
					if (stat.trig_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_ERR: begin
				if (stat.out_space) begin
					cmd.emit_err = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- hdl/akmt_dp.sv -----
// akmt_dp: datapath with configuration registers, slot table, trigger states and result register
// depends on akmt_pkg; commanded by akmt_ctrl

module akmt_dp #(
	parameter int ACTIVE_SLOTS = akmt_pkg::ACTIVE_SLOTS_DEF,
	parameter int MAX_TRIGGERS = akmt_pkg::MAX_TRIGGERS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  akmt_pkg::in_item_t                   in_data,
	input  logic                                 cfg_we,
	input  logic [akmt_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [akmt_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  akmt_pkg::ctrl_cmd_t                  cmd,
	output akmt_pkg::dp_stat_t                   stat,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output akmt_pkg::out_item_t                  out_data
);
	import akmt_pkg::*;

	localparam int SLOT_W   = (ACTIVE_SLOTS > 1) ? $clog2(ACTIVE_SLOTS) : 1;
	localparam int NUM_TRIG = (MAX_TRIGGERS < THRESHOLD_REGS) ? MAX_TRIGGERS : THRESHOLD_REGS;
	localparam int TI_W     = (NUM_TRIG > 1) ? $clog2(NUM_TRIG) : 1;
	localparam logic [SLOT_W-1:0]     LAST_SLOT  = SLOT_W'(ACTIVE_SLOTS - 1);
	localparam logic [TRIG_CNT_W-1:0] NUM_TRIG_C = TRIG_CNT_W'(NUM_TRIG);

	// configuration
	logic [TRIG_CNT_W-1:0] trig_cnt_q;
	logic [VAL_W-1:0]      thr_q [THRESHOLD_REGS];
	logic [VAL_W-1:0]      hyst_q;

	// current request
	in_item_t item_q;

	// slot table
	logic [POS_W-1:0]        slot_mem [ACTIVE_SLOTS];
	logic [ACTIVE_SLOTS-1:0] occ_q;

	// scan pipeline
	logic [SLOT_W-1:0] rd_addr_q;
	logic              rd_done_q;
	logic              rd_en;
	logic              rd_v_s1;
	logic [SLOT_W-1:0] rd_idx_s1;
	logic              rd_occ_s1;
	logic [POS_W-1:0]  rd_pos_s1;
	logic              hit;

	// triggers
	logic [NUM_TRIG-1:0]   trig_on_q;
	logic [TI_W-1:0]       trig_idx_q;
	logic [TRIG_CNT_W-1:0] used;
	logic [VAL_W:0]        hyst_sum;
	logic [NUM_TRIG-1:0]   change;
	logic                  later_change;

	// result register
	logic      out_valid_q;
	out_item_t out_q;
	logic      out_space;
	logic      trig_load;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_cnt_q <= TRIG_COUNT_RST;
			hyst_q     <= HYSTERESIS_RST;
			for (int k = 0; k < THRESHOLD_REGS; k++) begin
				thr_q[k] <= THRESHOLD_RST[k];
			end
		end else if (cfg_we) begin
			priority if (cfg_addr == REG_TRIGGER_COUNT) begin
				trig_cnt_q <= cfg_wdata[TRIG_CNT_W-1:0];
			end else if (cfg_addr >= REG_THRESHOLD_0 && cfg_addr <= REG_THRESHOLD_3) begin
				thr_q[TRIG_IDX_W'(cfg_addr - REG_THRESHOLD_0)] <= cfg_wdata;
			end else if (cfg_addr == REG_HYSTERESIS) begin
				hyst_q <= cfg_wdata;
			end else begin
				// unknown index, ignored
			end
		end
	end

	// request capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_q.cmd          <= CMD_UNUSED;
			item_q.key_position <= '0;
			item_q.sample_value <= '0;
		end else if (cmd.load_item) begin
			item_q <= in_data;
		end
	end

	// scan address walks the slots once per request
	assign rd_en = cmd.scan_rd && !rd_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_addr_q <= '0;
			rd_done_q <= 1'b0;
			rd_v_s1   <= 1'b0;
		end else if (cmd.load_item) begin
			rd_addr_q <= '0;
			rd_done_q <= 1'b0;
			rd_v_s1   <= 1'b0;
		end else begin
			rd_v_s1 <= rd_en;
			if (rd_en) begin
				rd_addr_q <= (rd_addr_q == LAST_SLOT) ? '0 : rd_addr_q + SLOT_W'(1);
				rd_done_q <= (rd_addr_q == LAST_SLOT);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_idx_s1 <= rd_addr_q;
			rd_occ_s1 <= occ_q[rd_addr_q];
		end
	end

	// slot position memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.slot_take) begin
			slot_mem[rd_idx_s1] <= item_q.key_position;
		end
		if (rd_en) begin
			rd_pos_s1 <= slot_mem[rd_addr_q];
		end
	end

	// occupancy bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (cmd.slot_take) begin
			occ_q[rd_idx_s1] <= 1'b1;
		end else if (cmd.slot_free) begin
			occ_q[rd_idx_s1] <= 1'b0;
		end
	end

	// register looks for a free slot, free and sample for a matching one
	always_comb begin
		if (item_q.cmd == CMD_REGISTER) begin
			hit = rd_v_s1 && !rd_occ_s1;
		end else begin
			hit = rd_v_s1 && rd_occ_s1 && (rd_pos_s1 == item_q.key_position);
		end
	end

	// trigger evaluation, all thresholds side by side
	assign used     = (trig_cnt_q > NUM_TRIG_C) ? NUM_TRIG_C : trig_cnt_q;
	assign hyst_sum = {1'b0, item_q.sample_value} + {1'b0, hyst_q};

	always_comb begin
		for (int k = 0; k < NUM_TRIG; k++) begin
			change[k] = (TRIG_CNT_W'(k) < used) &&
				((!trig_on_q[k] && item_q.sample_value > thr_q[k]) ||
				 (trig_on_q[k] && hyst_sum < {1'b0, thr_q[k]}));
		end
	end

	always_comb begin
		later_change = 1'b0;
		for (int k = 0; k < NUM_TRIG; k++) begin
			if (TRIG_CNT_W'(k) > TRIG_CNT_W'(trig_idx_q)) begin
				later_change = later_change | change[k];
			end
		end
	end

	assign trig_load = cmd.trig_step && change[trig_idx_q];

	// trigger states and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_on_q  <= '0;
			trig_idx_q <= '0;
		end else if (cmd.load_item) begin
			trig_idx_q <= '0;
		end else if (cmd.trig_step) begin
			trig_idx_q <= trig_idx_q + TI_W'(1);
			if (trig_load) begin
				trig_on_q[trig_idx_q] <= !trig_on_q[trig_idx_q];
			end
		end
	end

	// result register
	assign out_space = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (trig_load || cmd.emit_err) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_err) begin
			out_q.event_kind    <= (item_q.cmd == CMD_REGISTER) ? EV_FULL : EV_UNKNOWN;
			out_q.trigger_index <= '0;
			out_q.pressed       <= 1'b0;
			out_q.last          <= 1'b1;
		end else if (trig_load) begin
			out_q.event_kind    <= EV_TRIGGER;
			out_q.trigger_index <= TRIG_IDX_W'(trig_idx_q);
			out_q.pressed       <= !trig_on_q[trig_idx_q];
			out_q.last          <= !later_change;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// status to controller
	assign stat.item_cmd  = item_q.cmd;
	assign stat.hit       = hit;
	assign stat.scan_end  = rd_v_s1 && !hit && (rd_idx_s1 == LAST_SLOT);
	assign stat.out_space = out_space;
	assign stat.trig_last = (TRIG_CNT_W'(trig_idx_q) + TRIG_CNT_W'(1)) == used;
	assign stat.used_zero = (used == '0);

endmodule
